// ===== hdl/bist_pkg.sv =====
// ----------------------------------------------------------------------------
// bist_pkg
// Shared types and constants for the bounded integer set table unit.
// ----------------------------------------------------------------------------
package bist_pkg;

    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 5;
    localparam int ACT_W     = 2;
    localparam int DEPTH_DEF = 16;

    localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ===== hdl/bist_front.sv =====
// ----------------------------------------------------------------------------
// bist_front
// Request intake: accepts a request, decodes the action and pushes it.
// ----------------------------------------------------------------------------
module bist_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bist_pkg::ACT_W-1:0]      action,
    input  logic [bist_pkg::DATA_W-1:0]     value,
    input  logic                            pop,
    input  bist_pkg::q_status_t             q_status,
    output logic                            busy,
    output logic                            push,
    output bist_pkg::req_t                  push_req
);

    logic        busy_reg;
    logic        busy_next;
    bist_pkg::op_t op;

    always_comb
    begin
        case (action)
            bist_pkg::ACT_INSERT: op = bist_pkg::OP_INSERT;
            bist_pkg::ACT_REMOVE: op = bist_pkg::OP_REMOVE;
            bist_pkg::ACT_QUERY:  op = bist_pkg::OP_QUERY;
            default:              op = bist_pkg::OP_NONE;
        endcase
    end

    // one request in flight until the back end picks it up
    assign push           = start && !busy_reg && !q_status.full;
    assign push_req.op    = op;
    assign push_req.value = value;

    always_comb
    begin
        busy_next = busy_reg;
        if (push)
        begin
            busy_next = 1'b1;
        end
        else if (pop)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg || q_status.full;

endmodule

// ===== hdl/bist_queue.sv =====
// ----------------------------------------------------------------------------
// bist_queue
// Two-entry request queue between front and back end.
// ----------------------------------------------------------------------------
module bist_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bist_pkg::req_t          push_req,
    input  logic                    pop,
    output bist_pkg::req_t          head_req,
    output bist_pkg::q_status_t     q_status
);

    bist_pkg::req_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     fill_reg;
    logic [1:0]     fill_next;
    logic           do_push;
    logic           do_pop;

    assign do_push = push && (fill_reg != 2'd2);
    assign do_pop  = pop && (fill_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign head_req       = slot_reg[rd_ptr_reg];
    assign q_status.empty = (fill_reg == 2'd0);
    assign q_status.full  = (fill_reg == 2'd2);

endmodule

// ===== hdl/bist_back.sv =====
// ----------------------------------------------------------------------------
// bist_back
// Execution: parallel compare against the table, then insert/remove/query.
// ----------------------------------------------------------------------------
module bist_back
#(
    parameter int DEPTH = bist_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  bist_pkg::req_t                      head_req,
    input  bist_pkg::q_status_t                 q_status,
    output logic                                pop,
    input  logic                                cfg_we,
    input  logic [bist_pkg::COUNT_W-1:0]        cfg_data,
    output logic                                done,
    output logic                                success,
    output logic [bist_pkg::COUNT_W-1:0]        item_count
);

    // the 5-bit count never reaches past 31 entries
    localparam int SLOTS = (DEPTH < 31) ? DEPTH : 31;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [bist_pkg::COUNT_W-1:0] CAP_MAX = bist_pkg::COUNT_W'(SLOTS);

    logic [bist_pkg::DATA_W-1:0]    entry_reg [SLOTS];
    logic [bist_pkg::COUNT_W-1:0]   count_reg;
    logic [bist_pkg::COUNT_W-1:0]   count_next;
    logic [bist_pkg::COUNT_W-1:0]   cap_reg;

    logic                           s1_valid_reg;
    bist_pkg::op_t                  s1_op_reg;
    logic [bist_pkg::DATA_W-1:0]    s1_value_reg;
    logic                           s1_found_reg;
    logic [IDX_W-1:0]               s1_pos_reg;

    logic                           done_reg;
    logic                           success_reg;

    logic [SLOTS-1:0]               match;
    logic [IDX_W-1:0]               pos;
    logic [bist_pkg::COUNT_W-1:0]   eff_cap;
    logic                           insert_ok;
    logic                           remove_ok;
    logic                           query_ok;

    assign pop = !q_status.empty;

    // stage 1: compare head request against valid entries
    always_comb
    begin
        pos = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            match[j] = (entry_reg[j] == head_req.value) &&
                       (bist_pkg::COUNT_W'(j) < count_reg);
            if (match[j])
            begin
                pos = pos | IDX_W'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_op_reg    <= head_req.op;
            s1_value_reg <= head_req.value;
            s1_found_reg <= |match;
            s1_pos_reg   <= pos;
        end
    end

    // stage 2: apply
    always_comb
    begin
        eff_cap   = (cap_reg < CAP_MAX) ? cap_reg : CAP_MAX;
        insert_ok = s1_valid_reg && (s1_op_reg == bist_pkg::OP_INSERT) &&
                    !s1_found_reg && (count_reg < eff_cap);
        remove_ok = s1_valid_reg && (s1_op_reg == bist_pkg::OP_REMOVE) && s1_found_reg;
        query_ok  = s1_valid_reg && (s1_op_reg == bist_pkg::OP_QUERY) && s1_found_reg;
        count_next = count_reg;
        if (insert_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (remove_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cap_reg     <= bist_pkg::CAP_RESET;
            done_reg    <= 1'b0;
            success_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            done_reg    <= s1_valid_reg;
            success_reg <= insert_ok || remove_ok || query_ok;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // table: append at the count, close the gap on remove
    for (genvar j = 0; j < SLOTS; j++)
    begin : g_slot
        if (j < SLOTS - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (insert_ok && (count_reg == bist_pkg::COUNT_W'(j)))
                begin
                    entry_reg[j] <= s1_value_reg;
                end
                else if (remove_ok && (s1_pos_reg <= IDX_W'(j)))
                begin
                    entry_reg[j] <= entry_reg[j+1];
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (insert_ok && (count_reg == bist_pkg::COUNT_W'(j)))
                begin
                    entry_reg[j] <= s1_value_reg;
                end
            end
        end
    end

    assign done       = done_reg;
    assign success    = success_reg;
    assign item_count = count_reg;

endmodule

// ===== hdl/bounded_integer_set_table_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_set_table_unit
// Bounded set of distinct 32-bit values with insert, remove and query.
// ----------------------------------------------------------------------------
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------
//  request   | start, busy (start & !busy)  | action, value
//  result    | done (one-cycle strobe)      | success, item_count
//  config    | cfg_we                       | cfg_data (capacity limit)
//
//  A request is accepted only while busy is low: busy holds for one cycle
//  until the back end takes the request from the queue.
//  The result strobe follows acceptance through the queue and compare,
//  the update and the result register.
//  Reset clears the count and sets the capacity limit to 16; no clearing pass.
//  The result cannot be held off: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_unit
#(
    parameter int DEPTH = bist_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bist_pkg::ACT_W-1:0]          action,
    input  logic signed [bist_pkg::DATA_W-1:0]  value,
    output logic                                done,
    output logic                                success,
    output logic [bist_pkg::COUNT_W-1:0]        item_count,
    input  logic                                cfg_we,
    input  logic [bist_pkg::COUNT_W-1:0]        cfg_data
);

    logic                   push;
    logic                   pop;
    bist_pkg::req_t         push_req;
    bist_pkg::req_t         head_req;
    bist_pkg::q_status_t    q_status;

    bist_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .action   (action),
        .value    (value),
        .pop      (pop),
        .q_status (q_status),
        .busy     (busy),
        .push     (push),
        .push_req (push_req)
    );

    bist_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head_req (head_req),
        .q_status (q_status)
    );

    bist_back #(
        .DEPTH (DEPTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_req   (head_req),
        .q_status   (q_status),
        .pop        (pop),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .done       (done),
        .success    (success),
        .item_count (item_count)
    );

endmodule

// ===== tb/sv/bist_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bist_result_checker
// Watches the request, result and capacity channels of the bounded integer
// set table unit, keeps its own copy of the set and the capacity limit,
// predicts the result of every accepted request and compares each result
// strobe, field by field, with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module bist_result_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [bist_pkg::ACT_W-1:0]      action,
    input  logic [bist_pkg::DATA_W-1:0]     value,
    input  logic                            done,
    input  logic                            success,
    input  logic [bist_pkg::COUNT_W-1:0]    item_count,
    input  logic                            cfg_we,
    input  logic [bist_pkg::COUNT_W-1:0]    cfg_data,
    output int                              fail_count,
    output int                              outstanding,
    output int                              checked_count
);

    typedef struct packed {
        logic                           success;
        logic [bist_pkg::COUNT_W-1:0]   item_count;
    } set_result_t;

    logic [bist_pkg::DATA_W-1:0]    members [bist_pkg::DEPTH_DEF];
    logic [bist_pkg::COUNT_W-1:0]   member_count;
    logic [bist_pkg::COUNT_W-1:0]   cap_limit;
    set_result_t                    expected_results [$];
    set_result_t                    head;
    int                             errs;
    int                             n_checked;

    // Applies one request to the shadow set and returns the result it gives.
    function automatic set_result_t predict_set_op(bist_pkg::op_t op,
                                                   logic [bist_pkg::DATA_W-1:0] v);
        int          pos;
        int          cap;
        int          i;
        set_result_t r;
        pos = -1;
        for (i = 0; i < member_count; i++)
            if (pos < 0 && members[i] == v)
                pos = i;
        cap = (cap_limit > bist_pkg::DEPTH_DEF) ? bist_pkg::DEPTH_DEF : cap_limit;
        r.success = 1'b0;
        case (op)
            bist_pkg::OP_INSERT:
                if (pos < 0 && member_count < cap)
                begin
                    members[member_count] = v;
                    member_count++;
                    r.success = 1'b1;
                end
            bist_pkg::OP_REMOVE:
                if (pos >= 0)
                begin
                    for (i = pos; i + 1 < member_count; i++)
                        members[i] = members[i + 1];
                    member_count--;
                    r.success = 1'b1;
                end
            bist_pkg::OP_QUERY:
                r.success = (pos >= 0);
            default: ;
        endcase
        r.item_count = member_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count = '0;
            cap_limit    = bist_pkg::CAP_RESET;
            expected_results.delete();
            errs          = 0;
            n_checked     = 0;
            fail_count    <= 0;
            outstanding   <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: success %0b, item_count %0d",
                           success, item_count);
                    errs++;
                end
                else
                begin
                    head = expected_results.pop_front();
                    n_checked++;
                    if (success !== head.success)
                    begin
                        $error("success mismatch: expected %0b, got %0b",
                               head.success, success);
                        errs++;
                    end
                    if (item_count !== head.item_count)
                    begin
                        $error("item_count mismatch: expected %0d, got %0d",
                               head.item_count, item_count);
                        errs++;
                    end
                end
            end
            if (cfg_we)
                cap_limit = cfg_data;
            if (start && !busy)
                expected_results.push_back(predict_set_op(bist_pkg::op_t'(action), value));
            fail_count    <= errs;
            outstanding   <= expected_results.size();
            checked_count <= n_checked;
        end
    end

endmodule

// ===== tb/sv/bounded_integer_set_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_integer_set_table_unit_tb
// Drives insert, remove, query and unused requests into the set table unit:
// a directed run over the value extremes, duplicates, shifts on remove and a
// full set, then random requests drawn mostly from a small value pool across
// a range of capacity limits, some below the current count. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_unit_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int POOL_SIZE      = 20;
    localparam int PHASE_ITEMS    = 80;

    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               start    = 1'b0;
    logic [bist_pkg::ACT_W-1:0]         action   = bist_pkg::ACT_INSERT;
    logic [bist_pkg::DATA_W-1:0]        value    = '0;
    logic                               cfg_we   = 1'b0;
    logic [bist_pkg::COUNT_W-1:0]       cfg_data = '0;
    logic                               busy;
    logic                               done;
    logic                               success;
    logic [bist_pkg::COUNT_W-1:0]       item_count;

    int                                 fail_count;
    int                                 outstanding;
    int                                 checked_count;
    int                                 n_requests   = 0;
    int                                 n_settings   = 0;
    int                                 stall_cycles = 0;
    bit                                 idle_on      = 1'b1;
    logic [bist_pkg::DATA_W-1:0]        value_pool [POOL_SIZE];

    always #6 clk = ~clk;

    bounded_integer_set_table_unit i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .value      (value),
        .done       (done),
        .success    (success),
        .item_count (item_count),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    bist_result_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .value         (value),
        .done          (done),
        .success       (success),
        .item_count    (item_count),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Returns at the edge where the request is taken.
    task automatic issue(input bist_pkg::op_t op, input logic [bist_pkg::DATA_W-1:0] v);
        int gap;
        gap = (idle_on && $urandom_range(99) < 36) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        action <= op;
        value  <= v;
        do @(posedge clk); while (busy);
        n_requests++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [bist_pkg::COUNT_W-1:0] cap);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic random_request();
        int                             r;
        bist_pkg::op_t                  op;
        logic [bist_pkg::DATA_W-1:0]    v;
        r = $urandom_range(99);
        if (r < 40)
            op = bist_pkg::OP_INSERT;
        else if (r < 70)
            op = bist_pkg::OP_REMOVE;
        else if (r < 95)
            op = bist_pkg::OP_QUERY;
        else
            op = bist_pkg::OP_NONE;
        // mostly pool values so that inserts, removes and queries collide
        if ($urandom_range(99) < 85)
            v = value_pool[$urandom_range(POOL_SIZE - 1)];
        else
            v = $urandom;
        issue(op, v);
    endtask

    initial
    begin
        logic [bist_pkg::COUNT_W-1:0] phase_caps [10];
        phase_caps = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd16, 5'd12, 5'd17, 5'd2, 5'd16};
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, unused action, extremes, duplicate, shifts on remove
        issue(bist_pkg::OP_QUERY,  32'h8000_0000);
        issue(bist_pkg::OP_REMOVE, 32'h0000_0005);
        issue(bist_pkg::OP_NONE,   32'h0000_0000);
        issue(bist_pkg::OP_INSERT, 32'h8000_0000);
        issue(bist_pkg::OP_INSERT, 32'h7FFF_FFFF);
        issue(bist_pkg::OP_INSERT, 32'h0000_0000);
        issue(bist_pkg::OP_INSERT, 32'hFFFF_FFFF);
        issue(bist_pkg::OP_INSERT, 32'h7FFF_FFFF);
        issue(bist_pkg::OP_QUERY,  32'hFFFF_FFFF);
        issue(bist_pkg::OP_QUERY,  32'h0000_0001);
        issue(bist_pkg::OP_REMOVE, 32'h7FFF_FFFF);
        issue(bist_pkg::OP_QUERY,  32'h7FFF_FFFF);
        issue(bist_pkg::OP_QUERY,  32'h0000_0000);
        issue(bist_pkg::OP_REMOVE, 32'hFFFF_FFFF);
        issue(bist_pkg::OP_REMOVE, 32'h8000_0000);
        issue(bist_pkg::OP_NONE,   32'hFFFF_FFFF);

        // full set at a small capacity, then capacity below the count
        wait_drained();
        write_capacity(5'd2);
        issue(bist_pkg::OP_INSERT, 32'hA5A5_A5A5);
        issue(bist_pkg::OP_INSERT, 32'h5A5A_5A5A);
        issue(bist_pkg::OP_QUERY,  32'hA5A5_A5A5);
        wait_drained();
        write_capacity(5'd0);
        issue(bist_pkg::OP_INSERT, 32'h0000_3039);
        issue(bist_pkg::OP_REMOVE, 32'h0000_0000);
        issue(bist_pkg::OP_QUERY,  32'hA5A5_A5A5);

        for (int p = 0; p < 10; p++)
        begin
            wait_drained();
            write_capacity(phase_caps[p]);
            idle_on = (p != 5);
            repeat (PHASE_ITEMS) random_request();
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("%0d requests over %0d capacity limits from 0 to 31, %0d results compared",
                 n_requests, n_settings, checked_count);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
